// File: rtl/dpid_pkg.sv
package dpid_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned PowerW   = 32;
  localparam int unsigned ProductW = 2 * PowerW;
  localparam int unsigned RootW    = ProductW / 2;
  localparam int unsigned SumW     = 40;
  localparam int unsigned FactorW  = 9;
  localparam int unsigned MaxFactor = 256;
  localparam int unsigned StepW    = 3;
  localparam int unsigned RootCntW = $clog2(RootW);

  localparam logic [FactorW-1:0] FactorReset = FactorW'(1);
  localparam logic [FactorW-1:0] FactorMax   = FactorW'(MaxFactor);
  localparam logic [SumW-1:0]    SumMax      = {SumW{1'b1}};

  // Steps of the power sequence on the shared squarer
  localparam logic [StepW-1:0] StepXr  = 3'd0;
  localparam logic [StepW-1:0] StepXi  = 3'd1;
  localparam logic [StepW-1:0] StepYr  = 3'd2;
  localparam logic [StepW-1:0] StepYi  = 3'd3;
  localparam logic [StepW-1:0] StepPx  = 3'd4;
  localparam logic [StepW-1:0] StepPy  = 3'd5;
  localparam logic [StepW-1:0] StepSum = 3'd6;

  typedef enum logic [2:0] {
    StIdle,
    StPower,
    StStart,
    StRoot,
    StAcc
  } state_e;

  // Handshake between the sequencer and the root unit
  typedef struct packed {
    logic start;
  } root_req_t;

  typedef struct packed {
    logic done;
  } root_rsp_t;

endpackage

// File: rtl/dual_pol_intensity_downsampler.sv
// Dual-polarisation intensity downsampler. Each input item carries one
// complex X and one complex Y sample (16-bit two's complement parts) in
// s_axis_tdata, with s_axis_tlast marking the last sample of a subband run.
// The block forms Px = xr^2 + xi^2 and Py = yr^2 + yi^2, takes the exact
// integer root floor(sqrt(Px^2 + Py^2)) and adds it to a 40-bit saturating
// accumulator. After as many samples as the decimation factor (0 acts as 1,
// above 256 acts as 256) it emits the 40-bit sum on m_axis_tdata and clears
// the group. A run end emits a group that the sample completes and drops a
// partial one.
// Each item passes in order through accept, the shared squarer (six squares
// and the final add), the start of the root unit, the root unit at one result
// bit per cycle, and the accumulate step; s_axis_tready is high
// only while the block waits for an item. A finished sum waits in the output
// register while the next item is taken; the accumulate cycle holds only if
// that register is still full. Write the factor through cfg_we_i while idle.
module dual_pol_intensity_downsampler import dpid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: decimation factor
  input  logic               cfg_we_i,
  input  logic [FactorW-1:0] cfg_wdata_i,
  // Input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [15:0] x_real, [31:16] x_imag, [47:32] y_real, [63:48] y_imag
  input  logic [63:0]        s_axis_tdata,
  input  logic               s_axis_tlast,   // run_end
  // Result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [39:0] intensity_sum
  output logic [39:0]        m_axis_tdata
);

  state_e state_q, state_d;

  logic [FactorW-1:0] factor_q;
  logic [StepW-1:0]   step_q, step_d;

  // Latched sample
  logic signed [SampleW-1:0] xr_q, xi_q, yr_q, yi_q;
  logic                      last_q;

  // Power and radicand registers
  logic [PowerW-1:0]   px_q, py_q;
  logic [ProductW-1:0] rad_q;

  // Group state
  logic [SumW-1:0]    acc_q;
  logic [FactorW-1:0] cnt_q;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [SumW-1:0] out_data_q;

  // Shared squarer and root unit
  logic [PowerW-1:0]   sqr_op;
  logic [ProductW-1:0] prod;
  root_req_t           root_req;
  root_rsp_t           root_rsp;
  logic [RootW-1:0]    root;

  logic s_acc, out_free, acc_go;
  logic [SumW:0]      acc_sum;
  logic [SumW-1:0]    acc_new;
  logic [FactorW-1:0] cnt_new;
  logic [FactorW-1:0] factor_act;
  logic               emit;

  function automatic logic [SampleW-1:0] abs16(logic signed [SampleW-1:0] v);
    logic [SampleW-1:0] u;
    u = v;
    return v[SampleW-1] ? (~u + SampleW'(1)) : u;
  endfunction

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign acc_go   = (state_q == StAcc) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StPower;
          step_d  = StepXr;
        end
      end
      StPower: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepSum) begin
          state_d = StStart;
        end
      end
      StStart: state_d = StRoot;
      StRoot: begin
        if (root_rsp.done) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready  = 1'b0;
    root_req.start = 1'b0;
    case (state_q)
      StIdle:  s_axis_tready  = 1'b1;
      StStart: root_req.start = 1'b1;
      default: ;
    endcase
  end

  // Squarer operand for each power step; powers feed back for their squares
  always_comb begin
    sqr_op = '0;
    if (state_q == StPower) begin
      case (step_q)
        StepXr:  sqr_op = PowerW'(abs16(xr_q));
        StepXi:  sqr_op = PowerW'(abs16(xi_q));
        StepYr:  sqr_op = PowerW'(abs16(yr_q));
        StepYi:  sqr_op = PowerW'(abs16(yi_q));
        StepPx:  sqr_op = px_q;
        StepPy:  sqr_op = py_q;
        default: sqr_op = '0;
      endcase
    end
  end

  dpid_sqr u_sqr (
    .clk_i  (clk_i),
    .op_i   (sqr_op),
    .prod_o (prod)
  );

  dpid_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // Clamp the factor into 1..MaxFactor
  always_comb begin
    factor_act = factor_q;
    if (factor_q == '0) begin
      factor_act = FactorW'(1);
    end else if (factor_q > FactorMax) begin
      factor_act = FactorMax;
    end
  end

  // Saturating accumulate; count stays at or below MaxFactor
  assign acc_sum = (SumW+1)'(acc_q) + (SumW+1)'(root);
  assign acc_new = acc_sum[SumW] ? SumMax : acc_sum[SumW-1:0];
  assign cnt_new = cnt_q + FactorW'(1);
  assign emit    = cnt_new >= factor_act;

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (acc_go && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepXr;
      factor_q    <= FactorReset;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        factor_q <= cfg_wdata_i;
      end
      if (acc_go) begin
        // Clear on a full group or a run end; otherwise keep the running sum
        if (emit || last_q) begin
          acc_q <= '0;
          cnt_q <= '0;
        end else begin
          acc_q <= acc_new;
          cnt_q <= cnt_new;
        end
      end
    end
  end

  // Payload: latched sample, power steps, output data
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      xr_q   <= s_axis_tdata[15:0];
      xi_q   <= s_axis_tdata[31:16];
      yr_q   <= s_axis_tdata[47:32];
      yi_q   <= s_axis_tdata[63:48];
      last_q <= s_axis_tlast;
    end
    if (state_q == StPower) begin
      case (step_q)
        StepXi:  px_q  <= prod[PowerW-1:0];
        StepYr:  px_q  <= px_q + prod[PowerW-1:0];
        StepYi:  py_q  <= prod[PowerW-1:0];
        StepPx:  py_q  <= py_q + prod[PowerW-1:0];
        StepPy:  rad_q <= prod;
        StepSum: rad_q <= rad_q + prod;
        default: ;
      endcase
    end
    if (acc_go && emit) begin
      out_data_q <= acc_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/dpid_sqr.sv
module dpid_sqr import dpid_pkg::*; (
  input  logic                clk_i,
  input  logic [PowerW-1:0]   op_i,
  output logic [ProductW-1:0] prod_o
);

  logic [ProductW-1:0] prod_q;

  // Square the operand; register the product for the next step
  always_ff @(posedge clk_i) begin
    prod_q <= ProductW'(op_i) * ProductW'(op_i);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/dpid_isqrt.sv
module dpid_isqrt import dpid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  root_req_t           req_i,
  output root_rsp_t           rsp_o,
  input  logic [ProductW-1:0] rad_i,
  output logic [RootW-1:0]    root_o
);

  localparam int unsigned RemW = RootW + 3;

  logic                busy_q, busy_d;
  logic [RootCntW-1:0] cnt_q, cnt_d;
  logic [ProductW-1:0] sh_q, sh_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            ge;

  // One result bit per cycle: bring down two radicand bits, try (root<<2)|1
  assign rem_sh = {rem_q[RemW-3:0], sh_q[ProductW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      sh_d   = {sh_q[ProductW-3:0], 2'b00};
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[RootW-2:0], ge};
      cnt_d  = cnt_q + RootCntW'(1);
      if (cnt_q == RootCntW'(RootW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // Final iteration happens at this edge
  assign rsp_o.done = busy_q && (cnt_q == RootCntW'(RootW - 1));
  assign root_o     = root_q;

endmodule
